// File: hw/rtl/nmr_pkg.sv
// ----------------------------------------------------------------------------
// nmr_pkg
// Shared constants, types and helpers of the network MT response block.
// ----------------------------------------------------------------------------
package nmr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PART_W    = 32;
  localparam int WORD_W    = 64;
  localparam int CNT_W     = 20;
  localparam int ACC_W     = 66;
  localparam int QUO_W     = 34;
  localparam int QDEPTH    = 2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_DEVZERO  = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] hx0;
    logic [WORD_W-1:0] hx1;
    logic [WORD_W-1:0] hy0;
    logic [WORD_W-1:0] hy1;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] yxo;
    logic [WORD_W-1:0] yyo;
    logic [WORD_W-1:0] sdx;
    logic [WORD_W-1:0] sdy;
    logic [CNT_W-1:0]  base;
    logic              dev_zero;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PART_W-1:0] q;
  } div_rsp_t;

  function automatic logic signed [PART_W-1:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] pmax;
    logic signed [ACC_W-1:0] pmin;
    pmax = ACC_W'(64'sd2147483647);
    pmin = -pmax - ACC_W'(64'sd1);
    if (v > pmax) return 32'sh7FFFFFFF;
    else if (v < pmin) return 32'sh80000000;
    else return v[PART_W-1:0];
  endfunction

endpackage

// File: hw/rtl/nmr_queue.sv
// ----------------------------------------------------------------------------
// nmr_queue
// Short transaction queue between the front and back parts.
// ----------------------------------------------------------------------------
module nmr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nmr_pkg::item_t   push_item,
  input  logic             pop,
  output nmr_pkg::item_t   head,
  output nmr_pkg::q_stat_t q_stat
);
  localparam int PTR_W = (nmr_pkg::QDEPTH > 1) ? $clog2(nmr_pkg::QDEPTH) : 1;
  localparam int CW    = $clog2(nmr_pkg::QDEPTH + 1);

  nmr_pkg::item_t   mem [nmr_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CW-1:0]    count;

  assign q_stat.full  = (count == CW'(nmr_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(nmr_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(nmr_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

// File: hw/rtl/nmr_front.sv
// ----------------------------------------------------------------------------
// nmr_front
// Accepts input transactions, assigns data indices, flags zero deviations.
// ----------------------------------------------------------------------------
module nmr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nmr_pkg::WORD_W-1:0]  hx_pol0,
  input  logic [nmr_pkg::WORD_W-1:0]  hx_pol1,
  input  logic [nmr_pkg::WORD_W-1:0]  hy_pol0,
  input  logic [nmr_pkg::WORD_W-1:0]  hy_pol1,
  input  logic [nmr_pkg::WORD_W-1:0]  volt_pol0,
  input  logic [nmr_pkg::WORD_W-1:0]  volt_pol1,
  input  logic [nmr_pkg::WORD_W-1:0]  yx_observed,
  input  logic [nmr_pkg::WORD_W-1:0]  yy_observed,
  input  logic [nmr_pkg::WORD_W-1:0]  yx_deviation,
  input  logic [nmr_pkg::WORD_W-1:0]  yy_deviation,
  input  nmr_pkg::q_stat_t            q_stat,
  output logic                        push,
  output nmr_pkg::item_t              push_item
);
  logic [nmr_pkg::CNT_W-1:0] data_counter;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.hx0      = hx_pol0;
    push_item.hx1      = hx_pol1;
    push_item.hy0      = hy_pol0;
    push_item.hy1      = hy_pol1;
    push_item.v0       = volt_pol0;
    push_item.v1       = volt_pol1;
    push_item.yxo      = yx_observed;
    push_item.yyo      = yy_observed;
    push_item.sdx      = yx_deviation;
    push_item.sdy      = yy_deviation;
    push_item.base     = data_counter;
    push_item.dev_zero = (yx_deviation[63:32] == '0) || (yx_deviation[31:0] == '0) ||
                         (yy_deviation[63:32] == '0) || (yy_deviation[31:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_counter <= '0;
    end else if (push) begin
      data_counter <= data_counter + nmr_pkg::CNT_W'(4);
    end
  end
endmodule

// File: hw/rtl/nmr_div.sv
// ----------------------------------------------------------------------------
// nmr_div
// Radix-2 restoring divider: rounded, saturated fixed-point quotient.
// ----------------------------------------------------------------------------
module nmr_div (
  input  logic              clk,
  input  logic              rst,
  input  nmr_pkg::div_req_t req,
  output nmr_pkg::div_rsp_t rsp
);
  localparam int NW = nmr_pkg::WORD_W + nmr_pkg::FRAC_BITS + 1;
  localparam int HW = NW - nmr_pkg::QUO_W;
  localparam int W  = nmr_pkg::WORD_W;
  localparam int QW = nmr_pkg::QUO_W;
  localparam int CTW = $clog2(QW + 1);

  logic [NW-1:0]   nfull;
  logic [HW-1:0]   hi;
  logic            busy;
  logic [CTW-1:0]  cnt;
  logic [W-1:0]    rem;
  logic [QW-1:0]   bits;
  logic [QW-1:0]   quot;
  logic            ovf;
  logic            neg;
  logic [W-1:0]    den;
  logic [W:0]      rem2;
  logic            ge;
  logic [QW:0]     qr_full;
  logic [QW-1:0]   qr;
  logic [QW-1:0]   lim;
  logic [QW-1:0]   qm;
  logic [nmr_pkg::PART_W-1:0] qres;

  assign nfull = {req.num, (nmr_pkg::FRAC_BITS + 1)'(0)};
  assign hi    = nfull[NW-1:QW];
  assign rem2  = {rem, bits[QW-1]};
  assign ge    = rem2 >= {1'b0, den};

  assign qr_full = (QW + 1)'(quot) + (QW + 1)'(1);
  assign qr      = qr_full[QW:1];
  assign lim     = neg ? QW'(34'h080000000) : QW'(34'h07FFFFFFF);
  assign qm      = (ovf || (qr > lim)) ? lim : qr;
  assign qres    = neg ? -qm[nmr_pkg::PART_W-1:0] : qm[nmr_pkg::PART_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CTW'(QW);
        rem  <= W'(hi);
        bits <= nfull[QW-1:0];
        quot <= '0;
        ovf  <= W'(hi) >= req.den;
        neg  <= req.neg;
        den  <= req.den;
      end else if (busy) begin
        if (cnt != '0) begin
          rem  <= ge ? W'(rem2 - {1'b0, den}) : rem2[W-1:0];
          bits <= {bits[QW-2:0], 1'b0};
          quot <= {quot[QW-2:0], ge};
          cnt  <= cnt - CTW'(1);
        end else begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.q    <= qres;
        end
      end
    end
  end
endmodule

// File: hw/rtl/nmr_back.sv
// ----------------------------------------------------------------------------
// nmr_back
// Sequencer: shared multiplier for the cross and determinant products, then eight divisions unless an error skips them.
// ----------------------------------------------------------------------------
module nmr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  nmr_pkg::item_t             head,
  input  nmr_pkg::q_stat_t           q_stat,
  output logic                       pop,
  output nmr_pkg::div_req_t          div_req,
  input  nmr_pkg::div_rsp_t          div_rsp,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [nmr_pkg::WORD_W-1:0] yx_calc,
  output logic [nmr_pkg::WORD_W-1:0] yy_calc,
  output logic [nmr_pkg::WORD_W-1:0] yx_resid,
  output logic [nmr_pkg::WORD_W-1:0] yy_resid,
  output logic [nmr_pkg::CNT_W-1:0]  data_index_base,
  output logic [1:0]                 status
);
  localparam int AW = nmr_pkg::ACC_W;
  localparam int PW = nmr_pkg::PART_W;
  localparam logic [5:0] STEP_END = 6'd36;
  localparam logic signed [63:0] RND = 64'sd1 <<< (nmr_pkg::FRAC_BITS - 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHECK, S_DSTART, S_DWAIT, S_DONE} state_t;

  state_t state;
  logic [5:0] step;
  logic [2:0] div_idx;
  logic [1:0] status_r;
  logic [PW-1:0] res [8];

  logic signed [AW-1:0] acc [11];
  logic signed [63:0]   prod;
  logic                 p_en, p_rnd, p_neg;
  logic [3:0]           p_tgt;

  logic signed [PW-1:0] ma, mb;
  logic                 m_en, m_rnd, m_neg;
  logic [3:0]           m_tgt;
  logic signed [PW-1:0] ar, ai, br, bi, cr, ci, dr, di;
  logic signed [PW-1:0] dtr, dti, nxr, nxi, nyr, nyi;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] snum;
  logic signed [32:0]   diff;
  logic signed [PW-1:0] obs, sd, calc;
  logic [32:0]          sd_mag, diff_mag;
  logic                 load;

  assign dtr = nmr_pkg::sat32(acc[0]);
  assign dti = nmr_pkg::sat32(acc[1]);
  assign nxr = nmr_pkg::sat32(acc[2]);
  assign nxi = nmr_pkg::sat32(acc[3]);
  assign nyr = nmr_pkg::sat32(acc[4]);
  assign nyi = nmr_pkg::sat32(acc[5]);

  // cross operand groups: det, Yx numerator, Yy numerator
  always_comb begin
    case (step[4:3])
      2'd0: begin
        {ar, ai} = head.hx0; {br, bi} = head.hy1;
        {cr, ci} = head.hx1; {dr, di} = head.hy0;
      end
      2'd1: begin
        {ar, ai} = head.v0;  {br, bi} = head.hy1;
        {cr, ci} = head.v1;  {dr, di} = head.hy0;
      end
      default: begin
        {ar, ai} = head.v1;  {br, bi} = head.hx0;
        {cr, ci} = head.v0;  {dr, di} = head.hx1;
      end
    endcase
  end

  always_comb begin
    ma    = '0;
    mb    = '0;
    m_en  = 1'b0;
    m_rnd = 1'b0;
    m_neg = 1'b0;
    m_tgt = '0;
    if (step < 6'd24) begin
      m_en  = 1'b1;
      m_rnd = 1'b1;
      m_tgt = {1'b0, step[4:3], step[2]};
      case (step[2:0])
        3'd0:    begin ma = ar; mb = br; end
        3'd1:    begin ma = ai; mb = bi; m_neg = 1'b1; end
        3'd2:    begin ma = cr; mb = dr; m_neg = 1'b1; end
        3'd3:    begin ma = ci; mb = di; end
        3'd4:    begin ma = ar; mb = bi; end
        3'd5:    begin ma = ai; mb = br; end
        3'd6:    begin ma = cr; mb = di; m_neg = 1'b1; end
        default: begin ma = ci; mb = dr; m_neg = 1'b1; end
      endcase
    end else begin
      m_en = 1'b1;
      case (step)
        6'd26:   begin ma = dtr; mb = dtr; m_tgt = 4'd6; end
        6'd27:   begin ma = dti; mb = dti; m_tgt = 4'd6; end
        6'd28:   begin ma = nxr; mb = dtr; m_tgt = 4'd7; end
        6'd29:   begin ma = nxi; mb = dti; m_tgt = 4'd7; end
        6'd30:   begin ma = nxi; mb = dtr; m_tgt = 4'd8; end
        6'd31:   begin ma = nxr; mb = dti; m_tgt = 4'd8; m_neg = 1'b1; end
        6'd32:   begin ma = nyr; mb = dtr; m_tgt = 4'd9; end
        6'd33:   begin ma = nyi; mb = dti; m_tgt = 4'd9; end
        6'd34:   begin ma = nyi; mb = dtr; m_tgt = 4'd10; end
        6'd35:   begin ma = nyr; mb = dti; m_tgt = 4'd10; m_neg = 1'b1; end
        default: m_en = 1'b0;
      endcase
    end
  end

  assign term = p_rnd ? AW'((prod + RND) >>> nmr_pkg::FRAC_BITS) : AW'(prod);

  always_ff @(posedge clk) begin
    prod  <= ma * mb;
    p_rnd <= m_rnd;
    p_neg <= m_neg;
    p_tgt <= m_tgt;
    if (rst) begin
      p_en <= 1'b0;
    end else begin
      p_en <= (state == S_MUL) && (step < STEP_END) && m_en;
    end
    if (state == S_IDLE) begin
      for (int k = 0; k < 11; k++) begin
        acc[k] <= '0;
      end
    end else if (p_en) begin
      acc[p_tgt] <= acc[p_tgt] + (p_neg ? -term : term);
    end
  end

  // division operands
  always_comb begin
    case (div_idx[1:0])
      2'd0:    begin obs = head.yxo[63:32]; sd = head.sdx[63:32]; end
      2'd1:    begin obs = head.yxo[31:0];  sd = head.sdx[31:0];  end
      2'd2:    begin obs = head.yyo[63:32]; sd = head.sdy[63:32]; end
      default: begin obs = head.yyo[31:0];  sd = head.sdy[31:0];  end
    endcase
    calc     = res[{1'b0, div_idx[1:0]}];
    diff     = {obs[PW-1], obs} - {calc[PW-1], calc};
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    sd_mag   = sd[PW-1] ? -{sd[PW-1], sd} : {sd[PW-1], sd};
    case (div_idx[1:0])
      2'd0:    snum = acc[7];
      2'd1:    snum = acc[8];
      2'd2:    snum = acc[9];
      default: snum = acc[10];
    endcase
    div_req.start = (state == S_DSTART);
    if (div_idx[2]) begin
      div_req.neg = diff[32] ^ sd[PW-1];
      div_req.num = 64'(diff_mag);
      div_req.den = 64'(sd_mag);
    end else begin
      div_req.neg = snum[AW-1];
      div_req.num = snum[AW-1] ? 64'(-snum) : 64'(snum);
      div_req.den = acc[6][63:0];
    end
  end

  assign load = (state == S_DONE) && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      div_idx   <= '0;
      status_r  <= nmr_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          step <= '0;
          if (!q_stat.empty) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 6'd1;
          if (step == STEP_END) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          div_idx <= '0;
          if (acc[0] == '0 && acc[1] == '0) begin
            status_r <= nmr_pkg::ST_SINGULAR;
            state    <= S_DONE;
          end else if (head.dev_zero) begin
            status_r <= nmr_pkg::ST_DEVZERO;
            state    <= S_DONE;
          end else begin
            status_r <= nmr_pkg::ST_OK;
            state    <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            res[div_idx] <= div_rsp.q;
            if (div_idx == 3'd7) begin
              state <= S_DONE;
            end else begin
              div_idx <= div_idx + 3'd1;
              state   <= S_DSTART;
            end
          end
        end
        S_DONE: begin
          if (load) begin
            state           <= S_IDLE;
            data_index_base <= head.base;
            status          <= status_r;
            if (status_r == nmr_pkg::ST_OK) begin
              yx_calc  <= {res[0], res[1]};
              yy_calc  <= {res[2], res[3]};
              yx_resid <= {res[4], res[5]};
              yy_resid <= {res[6], res[7]};
            end else begin
              yx_calc  <= '0;
              yy_calc  <= '0;
              yx_resid <= '0;
              yy_resid <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/network_mt_response_residual.sv
// ----------------------------------------------------------------------------
// network_mt_response_residual
// Network-MT response solve (Cramer's rule) and normalized residuals.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready takes one frequency per transaction: fields
// for two polarizations, observed responses and their deviations.
// Output channel out_valid/out_ready gives one result transaction per input:
// calculated Yx/Yy, residuals, data_index_base and status.
// A two-entry queue decouples the input side from the solver, so inputs are
// taken while the solver works or while a result waits to be taken.
// Each transaction runs the cross and denominator products on one shared
// 32x32 multiplier, then eight divisions on one radix-2 divider; the solver
// finishes one transaction before it takes the next. Errors (singular
// determinant, zero deviation) skip the divisions. The index counter
// advances by 4 per accepted transaction.
// Reset clears the counter, the queue and the output valid.
// A stalled receiver holds the result; the queue then fills and in_ready drops.
// ----------------------------------------------------------------------------
module network_mt_response_residual (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [nmr_pkg::WORD_W-1:0] hx_pol0,
  input  logic [nmr_pkg::WORD_W-1:0] hx_pol1,
  input  logic [nmr_pkg::WORD_W-1:0] hy_pol0,
  input  logic [nmr_pkg::WORD_W-1:0] hy_pol1,
  input  logic [nmr_pkg::WORD_W-1:0] volt_pol0,
  input  logic [nmr_pkg::WORD_W-1:0] volt_pol1,
  input  logic [nmr_pkg::WORD_W-1:0] yx_observed,
  input  logic [nmr_pkg::WORD_W-1:0] yy_observed,
  input  logic [nmr_pkg::WORD_W-1:0] yx_deviation,
  input  logic [nmr_pkg::WORD_W-1:0] yy_deviation,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [nmr_pkg::WORD_W-1:0] yx_calc,
  output logic [nmr_pkg::WORD_W-1:0] yy_calc,
  output logic [nmr_pkg::WORD_W-1:0] yx_resid,
  output logic [nmr_pkg::WORD_W-1:0] yy_resid,
  output logic [nmr_pkg::CNT_W-1:0]  data_index_base,
  output logic [1:0]                 status
);
  nmr_pkg::q_stat_t  q_stat;
  nmr_pkg::item_t    push_item;
  nmr_pkg::item_t    head;
  nmr_pkg::div_req_t div_req;
  nmr_pkg::div_rsp_t div_rsp;
  logic              push;
  logic              pop;

  nmr_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .hx_pol0, .hx_pol1, .hy_pol0, .hy_pol1, .volt_pol0, .volt_pol1,
    .yx_observed, .yy_observed, .yx_deviation, .yy_deviation,
    .q_stat, .push, .push_item
  );

  nmr_queue u_queue (
    .clk, .rst, .push, .push_item, .pop, .head, .q_stat
  );

  nmr_div u_div (
    .clk, .rst, .req(div_req), .rsp(div_rsp)
  );

  nmr_back u_back (
    .clk, .rst, .head, .q_stat, .pop, .div_req, .div_rsp,
    .out_valid, .out_ready, .yx_calc, .yy_calc, .yx_resid, .yy_resid,
    .data_index_base, .status
  );
endmodule

// File: hw/rtl/nmr_checker.sv
// ----------------------------------------------------------------------------
// nmr_checker
// Port-level checks of the response block, bound to the top level.
// ----------------------------------------------------------------------------
module nmr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [nmr_pkg::WORD_W-1:0] yx_calc,
  input logic [nmr_pkg::WORD_W-1:0] yy_calc,
  input logic [nmr_pkg::WORD_W-1:0] yx_resid,
  input logic [nmr_pkg::WORD_W-1:0] yy_resid,
  input logic [nmr_pkg::CNT_W-1:0]  data_index_base,
  input logic [1:0]                 status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(data_index_base) && $stable(status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != nmr_pkg::ST_OK) |->
      (yx_calc == '0) && (yy_calc == '0) && (yx_resid == '0) && (yy_resid == '0))
    else $error("nonzero result on error status");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == nmr_pkg::ST_OK) || (status == nmr_pkg::ST_SINGULAR) ||
                  (status == nmr_pkg::ST_DEVZERO))
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");
endmodule

bind network_mt_response_residual nmr_checker u_nmr_checker (
  .clk, .rst, .out_valid, .out_ready, .yx_calc, .yy_calc, .yx_resid, .yy_resid,
  .data_index_base, .status
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the network MT response and residual block. A scoreboard
// predicts each calculated response, residual, index base and status from
// the accepted input transaction and checks every result transaction in
// order. Directed corner cases come first, then random frequencies with
// random gaps on both sides, a long receiver hold-off and a drained pause.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic signed [nmr_pkg::PART_W-1:0] part_t;
  typedef struct {
    part_t re;
    part_t im;
  } cplx_t;
  typedef struct {
    logic [nmr_pkg::WORD_W-1:0] hx0, hx1, hy0, hy1, v0, v1, yxo, yyo, sdx, sdy;
  } freq_t;
  typedef struct {
    logic [nmr_pkg::WORD_W-1:0] yx_calc, yy_calc, yx_resid, yy_resid;
    logic [nmr_pkg::CNT_W-1:0]  base;
    logic [1:0]                 status;
  } resp_t;

  class resp_scoreboard;
    resp_t                      expected_q[$];
    logic [nmr_pkg::CNT_W-1:0]  index_cnt;
    int                         errors;

    function new();
      index_cnt = '0;
      errors    = 0;
    endfunction

    function cplx_t split(logic [nmr_pkg::WORD_W-1:0] w);
      cplx_t c;
      c.re = w[63:32];
      c.im = w[31:0];
      return c;
    endfunction

    function longint rprod(part_t a, part_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + (64'sd1 <<< (nmr_pkg::FRAC_BITS - 1))) >>> nmr_pkg::FRAC_BITS;
    endfunction

    function part_t clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // a*b - c*d with rounded products
    function cplx_t cross_diff(cplx_t a, cplx_t b, cplx_t c, cplx_t d);
      cplx_t r;
      r.re = clamp32(rprod(a.re, b.re) - rprod(a.im, b.im)
                     - rprod(c.re, d.re) + rprod(c.im, d.im));
      r.im = clamp32(rprod(a.re, b.im) + rprod(a.im, b.re)
                     - rprod(c.re, d.im) - rprod(c.im, d.re));
      return r;
    endfunction

    function part_t fixdiv(logic neg, logic [66:0] n, logic [66:0] d);
      logic [66:0] q, r, lim;
      lim = neg ? 67'h80000000 : 67'h7FFFFFFF;
      q = n / d;
      r = n % d;
      if (q > (67'd1 << (32 - nmr_pkg::FRAC_BITS))) q = lim;
      else begin
        for (int i = 0; i <= nmr_pkg::FRAC_BITS; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d) begin
            r = r - d;
            q = q | 67'd1;
          end
        end
        q = (q + 67'd1) >> 1;
        if (q > lim) q = lim;
      end
      if (neg) q = -q;
      return q[31:0];
    endfunction

    function cplx_t cplx_div(cplx_t n, cplx_t d);
      logic signed [66:0] nr, ni, dr, di, s, den;
      cplx_t y;
      nr = n.re; ni = n.im; dr = d.re; di = d.im;
      den = dr * dr + di * di;
      s = nr * dr + ni * di;
      y.re = fixdiv(s < 0, s < 0 ? -s : s, den);
      s = ni * dr - nr * di;
      y.im = fixdiv(s < 0, s < 0 ? -s : s, den);
      return y;
    endfunction

    function part_t norm_resid(part_t obs, part_t calc, part_t sd);
      logic signed [66:0] diff, dev;
      diff = obs; diff = diff - calc;
      dev = sd;
      return fixdiv((diff < 0) != (dev < 0), diff < 0 ? -diff : diff,
                    dev < 0 ? -dev : dev);
    endfunction

    function resp_t solve_frequency(freq_t f);
      cplx_t hx0, hx1, hy0, hy1, v0, v1, yxo, yyo, sdx, sdy, det, nx, ny, yx, yy;
      resp_t e;
      hx0 = split(f.hx0); hx1 = split(f.hx1);
      hy0 = split(f.hy0); hy1 = split(f.hy1);
      v0 = split(f.v0); v1 = split(f.v1);
      yxo = split(f.yxo); yyo = split(f.yyo);
      sdx = split(f.sdx); sdy = split(f.sdy);
      det = cross_diff(hx0, hy1, hx1, hy0);
      nx = cross_diff(v0, hy1, v1, hy0);
      ny = cross_diff(v1, hx0, v0, hx1);
      e = '{default: '0};
      e.base = index_cnt;
      index_cnt = index_cnt + nmr_pkg::CNT_W'(4);
      if (det.re == 0 && det.im == 0) e.status = nmr_pkg::ST_SINGULAR;
      else if (sdx.re == 0 || sdx.im == 0 || sdy.re == 0 || sdy.im == 0)
        e.status = nmr_pkg::ST_DEVZERO;
      else begin
        e.status = nmr_pkg::ST_OK;
        yx = cplx_div(nx, det);
        yy = cplx_div(ny, det);
        e.yx_calc  = {yx.re, yx.im};
        e.yy_calc  = {yy.re, yy.im};
        e.yx_resid = {norm_resid(yxo.re, yx.re, sdx.re),
                      norm_resid(yxo.im, yx.im, sdx.im)};
        e.yy_resid = {norm_resid(yyo.re, yy.re, sdy.re),
                      norm_resid(yyo.im, yy.im, sdy.im)};
      end
      return e;
    endfunction

    function void note_frequency(freq_t f);
      expected_q.push_back(solve_frequency(f));
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(resp_t a);
      resp_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with no expected response");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("yx_calc", e.yx_calc, a.yx_calc);
      cmp("yy_calc", e.yy_calc, a.yy_calc);
      cmp("yx_resid", e.yx_resid, a.yx_resid);
      cmp("yy_resid", e.yy_resid, a.yy_resid);
      cmp("data_index_base", 64'(e.base), 64'(a.base));
      cmp("status", 64'(e.status), 64'(a.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [nmr_pkg::WORD_W-1:0] hx_pol0 = '0, hx_pol1 = '0, hy_pol0 = '0, hy_pol1 = '0;
  logic [nmr_pkg::WORD_W-1:0] volt_pol0 = '0, volt_pol1 = '0;
  logic [nmr_pkg::WORD_W-1:0] yx_observed = '0, yy_observed = '0;
  logic [nmr_pkg::WORD_W-1:0] yx_deviation = '0, yy_deviation = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [nmr_pkg::WORD_W-1:0] yx_calc, yy_calc, yx_resid, yy_resid;
  logic [nmr_pkg::CNT_W-1:0]  data_index_base;
  logic [1:0]                 status;

  resp_scoreboard sb = new();
  int  hold_cycles = 0;
  bit  quiet = 0;

  always #1 clk = ~clk;

  network_mt_response_residual dut (.*);

  // receiver: random stalls, long hold-off on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (quiet) out_ready <= 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 150);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{yx_calc, yy_calc, yx_resid, yy_resid, data_index_base, status});
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(30, 120);
  endfunction

  task automatic send_freq(freq_t f, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    hx_pol0      <= f.hx0; hx_pol1 <= f.hx1;
    hy_pol0      <= f.hy0; hy_pol1 <= f.hy1;
    volt_pol0    <= f.v0;  volt_pol1 <= f.v1;
    yx_observed  <= f.yxo; yy_observed <= f.yyo;
    yx_deviation <= f.sdx; yy_deviation <= f.sdy;
    do @(posedge clk); while (!in_ready);
    sb.note_frequency(f);
  endtask

  function automatic part_t rand_part();
    part_t v;
    int k;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: v = '0;
      2: case ($urandom_range(0, 3))
           0: v = 32'sh7FFFFFFF;
           1: v = 32'sh80000000;
           2: v = 32'sd1;
           default: v = -32'sd1;
         endcase
      default: begin
        k = $urandom_range(4, 24);
        v = $urandom_range(0, (1 << k) - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_word();
    return {rand_part(), rand_part()};
  endfunction

  function automatic part_t rand_dev();
    part_t v;
    if ($urandom_range(0, 39) == 0) return '0;
    do v = rand_part(); while (v == 0);
    return v;
  endfunction

  function automatic freq_t rand_freq();
    freq_t f;
    int r;
    r = $urandom_range(0, 99);
    f.hx0 = rand_word(); f.hx1 = rand_word();
    f.hy0 = rand_word(); f.hy1 = rand_word();
    f.v0 = rand_word(); f.v1 = rand_word();
    f.yxo = rand_word(); f.yyo = rand_word();
    f.sdx = {rand_dev(), rand_dev()};
    f.sdy = {rand_dev(), rand_dev()};
    if (r < 10) begin
      f.hx0 = {$urandom, $urandom}; f.hx1 = {$urandom, $urandom};
      f.hy0 = {$urandom, $urandom}; f.hy1 = {$urandom, $urandom};
      f.v0 = {$urandom, $urandom}; f.v1 = {$urandom, $urandom};
      f.sdx = {$urandom, $urandom}; f.sdy = {$urandom, $urandom};
    end else if (r < 15) begin
      f.hx1 = f.hx0;
      f.hy1 = f.hy0;
    end
    return f;
  endfunction

  function automatic freq_t basic_freq(logic [63:0] sd);
    freq_t f;
    f.hx0 = {32'h00010000, 32'h0}; f.hx1 = '0;
    f.hy0 = '0; f.hy1 = {32'h00010000, 32'h0};
    f.v0 = {32'h00020000, 32'h00008000};
    f.v1 = {32'hFFFD0000, 32'h00010000};
    f.yxo = {32'h00018000, 32'hFFFF0000};
    f.yyo = {32'hFFFC0000, 32'h00030000};
    f.sdx = sd; f.sdy = sd;
    return f;
  endfunction

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    freq_t f;
    freq_t dir_q[$];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    f = '{default: '0};
    dir_q.push_back(f);
    dir_q.push_back(basic_freq({32'h00010000, 32'h00008000}));
    dir_q.push_back(basic_freq({32'hFFFF0000, 32'hFFFE0000}));
    dir_q.push_back(basic_freq({32'h00000001, 32'hFFFFFFFF}));
    dir_q.push_back(basic_freq({32'h00010000, 32'h0}));
    f = basic_freq({32'h7FFFFFFF, 32'h80000000});
    f.hx0 = 64'h0000000100000000;
    f.hy1 = 64'h0000000000000001;
    dir_q.push_back(f);
    f = '{default: 64'h7FFFFFFF7FFFFFFF};
    dir_q.push_back(f);
    f = '{default: 64'h8000000080000000};
    dir_q.push_back(f);
    f = '{default: 64'h7FFFFFFF80000000};
    f.hx0 = 64'h800000007FFFFFFF;
    dir_q.push_back(f);
    f = '{default: 64'hFFFFFFFFFFFFFFFF};
    f.hx0 = 64'h0000000100000000;
    dir_q.push_back(f);
    f = basic_freq({32'h00010000, 32'h00010000});
    f.hx1 = f.hx0; f.hy1 = f.hy0;
    dir_q.push_back(f);
    f = basic_freq({32'h00000100, 32'h00000100});
    f.yxo = 64'h7FFFFFFF80000000;
    f.yyo = 64'h800000007FFFFFFF;
    dir_q.push_back(f);
    foreach (dir_q[i]) send_freq(dir_q[i], pick_gap());

    repeat (600) send_freq(rand_freq(), pick_gap());

    // receiver holds off while transactions keep coming
    hold_cycles = 2500;
    repeat (40) send_freq(rand_freq(), 0);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);

    quiet = 1;
    repeat (300) send_freq(rand_freq(), 0);
    quiet = 0;
    repeat (700) send_freq(rand_freq(), pick_gap());
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// File: network_mt_response_residual.f
hw/rtl/nmr_pkg.sv
hw/rtl/nmr_queue.sv
hw/rtl/nmr_front.sv
hw/rtl/nmr_div.sv
hw/rtl/nmr_back.sv
hw/rtl/network_mt_response_residual.sv
hw/rtl/nmr_checker.sv
sim/tb_top.sv
